/* rtl/core/sfbo_pkg.sv */
// ----------------------------------------------------------------------------
// sfbo_pkg
// Shared types and constants for the single-precision bit operation unit.
// ----------------------------------------------------------------------------
package sfbo_pkg;

  // Field layout of a single-precision word
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned OpW   = 3;

  localparam logic [ExpW-1:0]  ExpMax  = 8'hff;
  localparam logic [ExpW-1:0]  ExpTop  = 8'hfe;
  localparam logic [ExpW-1:0]  ExpBias = 8'd127;
  localparam logic [WordW-1:0] SignBit = 32'h8000_0000;
  localparam logic [WordW-1:0] MagMask = 32'h7fff_ffff;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_NEG  = 3'd0,
    OP_ABS  = 3'd1,
    OP_TWICE = 3'd2,
    OP_HALF = 3'd3,
    OP_F2I  = 3'd4,
    OP_I2F  = 3'd5
  } op_e;

endpackage

/* rtl/core/single_float_bit_ops_unit_top.sv */
// ----------------------------------------------------------------------------
// single_float_bit_ops_unit_top
// Stages: an accepted word passes the input register, then the result
//   register after the operation logic.
// Throughput: one word per cycle while the output is not stalled; each stage takes a word when empty or draining.
// Reset: asynchronous, active low; clears both stage valid flags only.
// ----------------------------------------------------------------------------
module single_float_bit_ops_unit_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sfbo_pkg::OpW-1:0]   op_i,
  input  logic [sfbo_pkg::WordW-1:0] operand_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sfbo_pkg::WordW-1:0] result_o
);

  logic                       s1_valid_q;
  sfbo_pkg::op_e              op_q;
  logic [sfbo_pkg::WordW-1:0] operand_q;
  logic                       s2_valid_q;
  logic [sfbo_pkg::WordW-1:0] result_q;
  logic [sfbo_pkg::WordW-1:0] result_d;
  logic                       s2_ready;

  // stage readiness: a stage takes a word when empty or draining
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q      <= sfbo_pkg::op_e'(op_i);
      operand_q <= operand_i;
    end
  end

  // operation logic
  sfbo_alu u_alu (
    .op_i      (op_q),
    .operand_i (operand_q),
    .result_o  (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign result_o    = result_q;

  // accepted word lands in the input register
  a_in_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted word not held in input register");

  // a word moving out of the input register shows up as a result
  a_s1_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_o)
    else $error("word lost between stages");

  // backpressure only when both stages are full and the output stalls
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipe");

endmodule

/* rtl/core/sfbo_i2f.sv */
// ----------------------------------------------------------------------------
// sfbo_i2f
// Two's complement integer to single-precision conversion: leading-one
// detect, normalizing shift and round to nearest even.
// ----------------------------------------------------------------------------
module sfbo_i2f (
  input  logic [sfbo_pkg::WordW-1:0] int_i,
  output logic [sfbo_pkg::WordW-1:0] flt_o
);

  logic                        sign;
  logic [sfbo_pkg::WordW-1:0]  mag;
  logic [4:0]                  top;
  logic [sfbo_pkg::WordW-1:0]  norm;
  logic                        guard;
  logic                        sticky;
  logic                        round_up;
  logic [sfbo_pkg::FracW+1:0]  mant;
  logic [sfbo_pkg::ExpW-1:0]   exp_val;

  // magnitude; the most negative integer maps onto itself
  assign sign = int_i[sfbo_pkg::WordW-1];
  assign mag  = sign ? (~int_i + 32'd1) : int_i;

  // position of the leading one
  always_comb begin
    top = 5'd0;
    for (int k = 1; k < sfbo_pkg::WordW; k++) begin
      if (mag[k]) top = 5'(k);
    end
  end

  // shift the leading one up to bit 31; 31 - top is ~top
  assign norm = mag << (~top);

  // nearest even on the bits below the kept 24
  assign guard    = norm[7];
  assign sticky   = |norm[6:0];
  assign round_up = guard & (sticky | norm[8]);
  assign mant     = {1'b0, norm[31:8]} + {24'd0, round_up};

  // carry out of the rounding bumps the exponent
  assign exp_val = sfbo_pkg::ExpBias + {3'd0, top} + {7'd0, mant[24]};

  always_comb begin
    if (int_i == '0) begin
      flt_o = '0;
    end else begin
      flt_o = {sign, exp_val, mant[sfbo_pkg::FracW-1:0]};
    end
  end

endmodule

/* rtl/core/sfbo_alu.sv */
// ----------------------------------------------------------------------------
// sfbo_alu
// Combinational operation logic: sign ops, scale by two, float to int and
// int to float.
// ----------------------------------------------------------------------------
module sfbo_alu (
  input  sfbo_pkg::op_e              op_i,
  input  logic [sfbo_pkg::WordW-1:0] operand_i,
  output logic [sfbo_pkg::WordW-1:0] result_o
);

  logic                              sign;
  logic [sfbo_pkg::ExpW-1:0]         exp_f;
  logic [sfbo_pkg::FracW-1:0]        frac;
  logic                              is_nan;
  logic [sfbo_pkg::WordW-1:0]        neg_res;
  logic [sfbo_pkg::WordW-1:0]        abs_res;
  logic [sfbo_pkg::WordW-1:0]        twice_res;
  logic [sfbo_pkg::WordW-1:0]        half_res;
  logic [sfbo_pkg::WordW-1:0]        f2i_res;
  logic [sfbo_pkg::WordW-1:0]        i2f_res;
  logic                              half_up;
  logic [sfbo_pkg::FracW:0]          half_sig;
  logic [sfbo_pkg::ExpW-1:0]         f2i_exp;
  logic [sfbo_pkg::FracW:0]          f2i_sig;
  logic [sfbo_pkg::WordW-1:0]        f2i_mag;

  assign sign   = operand_i[sfbo_pkg::WordW-1];
  assign exp_f  = operand_i[sfbo_pkg::WordW-2:sfbo_pkg::FracW];
  assign frac   = operand_i[sfbo_pkg::FracW-1:0];
  assign is_nan = (exp_f == sfbo_pkg::ExpMax) && (frac != '0);

  // sign-only ops leave NaNs alone
  assign neg_res = is_nan ? operand_i : (operand_i ^ sfbo_pkg::SignBit);
  assign abs_res = is_nan ? operand_i : (operand_i & sfbo_pkg::MagMask);

  // twice: denormal shifts left, top exponent overflows to infinity
  always_comb begin
    if (exp_f == '0) begin
      twice_res = {sign, 7'd0, frac, 1'b0};
    end else if (exp_f < sfbo_pkg::ExpTop) begin
      twice_res = {sign, exp_f + 8'd1, frac};
    end else if (exp_f == sfbo_pkg::ExpTop) begin
      twice_res = {sign, sfbo_pkg::ExpMax, 23'd0};
    end else begin
      twice_res = operand_i;
    end
  end

  // half: exponents 0 and 1 drop into denormals with nearest-even rounding
  assign half_up  = frac[0] & frac[1];
  assign half_sig = {1'b0, (exp_f == 8'd1), frac[sfbo_pkg::FracW-1:1]}
                    + {23'd0, half_up};
  always_comb begin
    if (exp_f == '0 || exp_f == 8'd1) begin
      half_res = {sign, 7'd0, half_sig};
    end else if (exp_f != sfbo_pkg::ExpMax) begin
      half_res = {sign, exp_f - 8'd1, frac};
    end else begin
      half_res = operand_i;
    end
  end

  // float to int, truncating toward zero
  assign f2i_exp = exp_f - sfbo_pkg::ExpBias;
  assign f2i_sig = {1'b1, frac};
  always_comb begin
    f2i_mag = '0;
    if (f2i_exp < 8'd23) begin
      f2i_mag = {8'd0, f2i_sig} >> (5'd23 - f2i_exp[4:0]);
    end else begin
      f2i_mag = {8'd0, f2i_sig} << (f2i_exp[4:0] - 5'd23);
    end
  end
  always_comb begin
    if (exp_f < sfbo_pkg::ExpBias) begin
      f2i_res = '0;
    end else if (f2i_exp >= 8'd31) begin
      f2i_res = sfbo_pkg::SignBit;
    end else begin
      f2i_res = sign ? (~f2i_mag + 32'd1) : f2i_mag;
    end
  end

  // int to float
  sfbo_i2f u_i2f (
    .int_i (operand_i),
    .flt_o (i2f_res)
  );

  // op select; unused codes pass the operand through
  always_comb begin
    unique case (op_i)
      sfbo_pkg::OP_NEG:   result_o = neg_res;
      sfbo_pkg::OP_ABS:   result_o = abs_res;
      sfbo_pkg::OP_TWICE: result_o = twice_res;
      sfbo_pkg::OP_HALF:  result_o = half_res;
      sfbo_pkg::OP_F2I:   result_o = f2i_res;
      sfbo_pkg::OP_I2F:   result_o = i2f_res;
      default:            result_o = operand_i;
    endcase
  end

endmodule

/* test/single_float_bit_ops_unit_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_float_bit_ops_unit_top_test
// Self-checking bench for the single-precision bit operation unit. A queue of
// op/operand words, directed corner values first and then random ones, feeds
// a clocked driver. A clocked monitor compares each result word with a local
// computation of the expected value. Both sides idle at random, and the
// receiver holds off once for a long stretch so that the pipe fills up.
// ----------------------------------------------------------------------------
module single_float_bit_ops_unit_top_test;

  typedef logic [sfbo_pkg::OpW-1:0] op_t;

  // Op codes that the unit passes through unchanged
  localparam logic [sfbo_pkg::OpW-1:0] OpPass6 = 3'd6;
  localparam logic [sfbo_pkg::OpW-1:0] OpPass7 = 3'd7;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 8;
  localparam int HoldStart = 150;
  localparam int HoldCycles = 80;
  localparam int QuietLo = 320;
  localparam int QuietHi = 440;
  localparam int RandomWords = 650;

  typedef struct packed {
    logic [sfbo_pkg::OpW-1:0]   op;
    logic [sfbo_pkg::WordW-1:0] operand;
  } word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [sfbo_pkg::OpW-1:0]   op_i = '0;
  logic [sfbo_pkg::WordW-1:0] operand_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [sfbo_pkg::WordW-1:0] result_o;

  word_t                      pending_q[$];
  logic [sfbo_pkg::WordW-1:0] expected_q[$];
  int                         n_sent = 0;
  int                         err_cnt = 0;
  int                         cycle_cnt = 0;
  int                         hold_cnt = 0;
  logic                       hold_done = 1'b0;
  logic                       quiet;

  single_float_bit_ops_unit_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .operand_i  (operand_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result_o)
  );

  // Clock and reset
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // ------------------------------------------------------------------------
  // Expected-value computation
  // ------------------------------------------------------------------------
  function automatic logic is_nan(logic [sfbo_pkg::WordW-1:0] f);
    return f[30:23] == sfbo_pkg::ExpMax && f[22:0] != '0;
  endfunction

  function automatic logic [sfbo_pkg::WordW-1:0] fp_twice(
    logic [sfbo_pkg::WordW-1:0] f);
    logic [sfbo_pkg::ExpW-1:0] ex;
    ex = f[30:23];
    // denormal: fraction shifts left, a carry lands in the exponent
    if (ex == 8'd0) return {f[31], 7'd0, f[22:0], 1'b0};
    if (ex < sfbo_pkg::ExpTop) return {f[31], ex + 8'd1, f[22:0]};
    if (ex == sfbo_pkg::ExpTop) return {f[31], sfbo_pkg::ExpMax, 23'd0};
    return f;
  endfunction

  function automatic logic [sfbo_pkg::WordW-1:0] fp_half(
    logic [sfbo_pkg::WordW-1:0] f);
    logic [sfbo_pkg::ExpW-1:0]  ex;
    logic [sfbo_pkg::WordW-1:0] frac;
    logic [sfbo_pkg::WordW-1:0] rnd;
    ex   = f[30:23];
    frac = {9'd0, f[22:0]};
    // round to nearest even on the bit shifted out
    rnd  = {31'd0, f[0] & f[1]};
    if (ex == 8'd0) return {f[31], 31'd0} | ((frac >> 1) + rnd);
    if (ex == 8'd1) return {f[31], 31'd0} | ((32'h0040_0000 | (frac >> 1)) + rnd);
    if (ex != sfbo_pkg::ExpMax) return {f[31], ex - 8'd1, f[22:0]};
    return f;
  endfunction

  function automatic logic [sfbo_pkg::WordW-1:0] fp_to_int(
    logic [sfbo_pkg::WordW-1:0] f);
    logic [sfbo_pkg::WordW-1:0] mant;
    logic [sfbo_pkg::WordW-1:0] mag;
    int                         sh;
    mant = {8'd0, 1'b1, f[22:0]};
    if (f[30:23] < sfbo_pkg::ExpBias) return '0;
    sh = int'(f[30:23]) - int'(sfbo_pkg::ExpBias);
    if (sh < 23) mag = mant >> (23 - sh);
    else if (sh < 31) mag = mant << (sh - 23);
    else return sfbo_pkg::SignBit;
    return f[31] ? -mag : mag;
  endfunction

  function automatic logic [sfbo_pkg::WordW-1:0] int_to_fp(
    logic [sfbo_pkg::WordW-1:0] i);
    logic [sfbo_pkg::WordW-1:0] mag;
    logic [sfbo_pkg::WordW-1:0] sig;
    logic [sfbo_pkg::WordW-1:0] rest;
    logic [sfbo_pkg::WordW-1:0] halfway;
    logic [sfbo_pkg::ExpW-1:0]  ex;
    int                         top;
    int                         sh;
    if (i == '0) return '0;
    mag = i[31] ? -i : i;
    top = 31;
    while (top > 0 && !mag[top]) top--;
    ex = sfbo_pkg::ExpBias + 8'(top);
    if (top <= 23) begin
      sig = mag << (23 - top);
    end else begin
      sh      = top - 23;
      rest    = mag & ((32'd1 << sh) - 32'd1);
      halfway = 32'd1 << (sh - 1);
      sig     = mag >> sh;
      if (rest > halfway || (rest == halfway && sig[0])) sig = sig + 32'd1;
      if (sig == 32'h0100_0000) ex = ex + 8'd1;
    end
    return {i[31], ex, sig[22:0]};
  endfunction

  function automatic logic [sfbo_pkg::WordW-1:0] bit_op_result(
    logic [sfbo_pkg::OpW-1:0]   op,
    logic [sfbo_pkg::WordW-1:0] x);
    case (op)
      sfbo_pkg::OP_NEG:   return is_nan(x) ? x : (x ^ sfbo_pkg::SignBit);
      sfbo_pkg::OP_ABS:   return is_nan(x) ? x : (x & sfbo_pkg::MagMask);
      sfbo_pkg::OP_TWICE: return fp_twice(x);
      sfbo_pkg::OP_HALF:  return fp_half(x);
      sfbo_pkg::OP_F2I:   return fp_to_int(x);
      sfbo_pkg::OP_I2F:   return int_to_fp(x);
      default:            return x;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Random operands
  // ------------------------------------------------------------------------
  function automatic logic [sfbo_pkg::WordW-1:0] rand_float();
    logic [sfbo_pkg::ExpW-1:0] ex;
    logic [22:0]               fr;
    case ($urandom_range(6))
      0: ex = 8'd0;
      1: ex = 8'd1;
      2: ex = sfbo_pkg::ExpTop;
      3: ex = sfbo_pkg::ExpMax;
      4: ex = 8'($urandom_range(120, 162));
      default: ex = 8'($urandom());
    endcase
    case ($urandom_range(5))
      0: fr = '0;
      1: fr = '1;
      default: fr = 23'($urandom());
    endcase
    return {1'($urandom()), ex, fr};
  endfunction

  function automatic logic [sfbo_pkg::WordW-1:0] rand_int();
    logic [sfbo_pkg::WordW-1:0] v;
    v = $urandom() >> $urandom_range(31);
    return $urandom_range(1) ? -v : v;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus and end of run
  // ------------------------------------------------------------------------
  task automatic add_word(logic [sfbo_pkg::OpW-1:0] op, logic [sfbo_pkg::WordW-1:0] x);
    pending_q.push_back('{op: op, operand: x});
  endtask

  initial begin : stim
    logic [sfbo_pkg::OpW-1:0]   op;
    logic [sfbo_pkg::WordW-1:0] x;
    // sign ops: zero, NaN kept, infinity
    add_word(sfbo_pkg::OP_NEG, 32'h0000_0000);
    add_word(sfbo_pkg::OP_NEG, 32'h7fc0_0001);
    add_word(sfbo_pkg::OP_ABS, 32'hff80_0000);
    add_word(sfbo_pkg::OP_ABS, 32'hffc0_0000);
    // twice: overflow, denormal carry, largest denormal, inf, NaN
    add_word(sfbo_pkg::OP_TWICE, 32'h7f00_0000);
    add_word(sfbo_pkg::OP_TWICE, 32'h0040_0000);
    add_word(sfbo_pkg::OP_TWICE, 32'h807f_ffff);
    add_word(sfbo_pkg::OP_TWICE, 32'hff80_0000);
    add_word(sfbo_pkg::OP_TWICE, 32'h7f80_0001);
    // half: rounding into denormals, inf, NaN
    add_word(sfbo_pkg::OP_HALF, 32'h0000_0003);
    add_word(sfbo_pkg::OP_HALF, 32'h0080_0003);
    add_word(sfbo_pkg::OP_HALF, 32'h80ff_ffff);
    add_word(sfbo_pkg::OP_HALF, 32'h7f80_0000);
    add_word(sfbo_pkg::OP_HALF, 32'hffff_ffff);
    // float to int: 2^31 both signs, largest in range, below one, inf
    add_word(sfbo_pkg::OP_F2I, 32'h4f00_0000);
    add_word(sfbo_pkg::OP_F2I, 32'hcf00_0000);
    add_word(sfbo_pkg::OP_F2I, 32'h4eff_ffff);
    add_word(sfbo_pkg::OP_F2I, 32'hbf7f_ffff);
    add_word(sfbo_pkg::OP_F2I, 32'h7f80_0000);
    // int to float: zero, most negative, largest, ties either way, -1
    add_word(sfbo_pkg::OP_I2F, 32'h0000_0000);
    add_word(sfbo_pkg::OP_I2F, 32'h8000_0000);
    add_word(sfbo_pkg::OP_I2F, 32'h7fff_ffff);
    add_word(sfbo_pkg::OP_I2F, 32'h0100_0001);
    add_word(sfbo_pkg::OP_I2F, 32'h0100_0003);
    add_word(sfbo_pkg::OP_I2F, 32'hffff_ffff);
    // pass-through codes
    add_word(OpPass6, 32'h1234_5678);
    add_word(OpPass7, 32'hdead_beef);

    repeat (RandomWords) begin
      if ($urandom_range(19) == 0) op = $urandom_range(1) ? OpPass6 : OpPass7;
      else op = op_t'($urandom_range(sfbo_pkg::OP_I2F));
      case ($urandom_range(4))
        0: x = $urandom();
        default: x = (op == sfbo_pkg::OP_I2F) ? rand_int() : rand_float();
      endcase
      add_word(op, x);
    end

    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // No idling on either side for a stretch of the run
  assign quiet = n_sent >= QuietLo && n_sent < QuietHi;

  // ------------------------------------------------------------------------
  // Driver: offers the next queued word, holds it until accepted
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i       <= '0;
      operand_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(bit_op_result(op_i, operand_i));
        n_sent <= n_sent + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
          in_valid_i <= 1'b1;
          op_i       <= pending_q[0].op;
          operand_i  <= pending_q[0].operand;
          void'(pending_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: checks each result word, drives ready with a long hold-off once
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result_o: unexpected word, expected none, actual %h", result_o);
          err_cnt <= err_cnt + 1;
        end else begin
          if (result_o !== expected_q[0]) begin
            $error("result_o: expected %h, actual %h", expected_q[0], result_o);
            err_cnt <= err_cnt + 1;
          end
          void'(expected_q.pop_front());
        end
      end
      if (!hold_done && n_sent >= HoldStart) begin
        hold_done   <= 1'b1;
        hold_cnt    <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || $urandom_range(99) >= 15;
      end
    end
  end

endmodule

/* files.f */
rtl/core/sfbo_pkg.sv
rtl/core/sfbo_i2f.sv
rtl/core/sfbo_alu.sv
rtl/core/single_float_bit_ops_unit_top.sv
test/single_float_bit_ops_unit_top_test.sv
